[sv/next_hop_path_length_unit_macros.svh]
// Assertion macros for the next-hop path length unit.
`ifndef NEXT_HOP_PATH_LENGTH_UNIT_MACROS_SVH
`define NEXT_HOP_PATH_LENGTH_UNIT_MACROS_SVH

// Implication checked every clock edge, held off during reset.
`define NHPL_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock edge, held off during reset.
`define NHPL_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/nhpl_pkg.sv]
`timescale 1ns / 1ps
package nhpl_pkg;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W = 2 * DIFF_W;
  localparam int unsigned SUMSQ_W = SQ_W + 2;
  localparam int unsigned ROOT_W = SUMSQ_W / 2;
  localparam int unsigned LEN_W = 40;

  localparam logic [1:0] OP_WRITE_POS = 2'd0;
  localparam logic [1:0] OP_WRITE_HOP = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  // request into the distance unit and its answer
  typedef struct packed {
    logic start;
    pos_t p;
    pos_t q;
  } dist_req_t;

  typedef struct packed {
    logic done;
    logic [ROOT_W:0] len;
  } dist_rsp_t;
endpackage

[sv/nhpl_dist.sv]
`timescale 1ns / 1ps
// Euclidean distance: three squares summed in turn, then a bit-pair
// restoring square root, one result bit a cycle, rounded to nearest.
module nhpl_dist (
  input  logic               clk,
  input  logic               rst,
  input  nhpl_pkg::dist_req_t req,
  output nhpl_pkg::dist_rsp_t rsp
);
  import nhpl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} st_t;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  st_t state;
  pos_t p, q;
  logic [1:0] axis;
  logic [SUMSQ_W-1:0] rem;
  logic [SUMSQ_W-1:0] acc;
  logic [ROOT_W:0] root;
  logic [CNT_W-1:0] cnt;
  logic signed [DIFF_W-1:0] d;
  logic [DIFF_W-1:0] m;
  logic [SQ_W-1:0] sq;
  logic [ROOT_W+1:0] trial;
  logic [ROOT_W+1:0] rem_hi;
  logic [ROOT_W+1:0] rem_hi_next;
  logic [SUMSQ_W-1:0] rem_next;

  always_comb begin
    case (axis)
      2'd0: d = DIFF_W'(p.x) - DIFF_W'(q.x);
      2'd1: d = DIFF_W'(p.y) - DIFF_W'(q.y);
      default: d = DIFF_W'(p.z) - DIFF_W'(q.z);
    endcase
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    sq = SQ_W'(m) * SQ_W'(m);
  end

  // one root step: bring down two bits of the radicand
  always_comb begin
    rem_hi = {rem[ROOT_W-1:0], acc[SUMSQ_W-1 -: 2]};
    trial = {root[ROOT_W-1:0], 2'b01};
    if (rem_hi >= trial) rem_hi_next = rem_hi - trial;
    else rem_hi_next = rem_hi;
    rem_next = SUMSQ_W'(rem_hi_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rsp.done <= 1'b0;
          if (req.start) begin
            p <= req.p;
            q <= req.q;
            axis <= 2'd0;
            acc <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          rsp.done <= 1'b0;
          acc <= acc + SUMSQ_W'(sq);
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            rem <= '0;
            root <= '0;
            cnt <= CNT_W'(ROOT_W);
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (cnt == '0) begin
            rsp.len <= (rem > SUMSQ_W'(root)) ? root + 1'b1 : root;
            rsp.done <= 1'b1;
            state <= S_IDLE;
          end else begin
            rsp.done <= 1'b0;
            rem <= rem_next;
            root <= {root[ROOT_W-1:0], (rem_hi >= trial)};
            acc <= {acc[SUMSQ_W-3:0], 2'b00};
            cnt <= cnt - 1'b1;
          end
        end
        default: begin
          rsp.done <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

[sv/next_hop_path_length_unit.sv]
`timescale 1ns / 1ps
// Next-hop path length unit; writes set a position or a table entry.
// A query walks the next-hop table from point_a to point_b; each distance
// takes two memory reads (RD_HOP, RD_POS) and then the distance unit (start,
// three squares, a 26-step root, rounding). Equal or out-of-range endpoints
// answer on the next cycle. Input is stalled while a query runs and while a
// result waits under out_stall.
module next_hop_path_length_unit #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic [nhpl_pkg::IDX_W-1:0]           point_a,
  input  logic [nhpl_pkg::IDX_W-1:0]           point_b,
  input  logic signed [7:0]                    hop_value,
  input  logic signed [nhpl_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [nhpl_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [nhpl_pkg::COORD_W-1:0]  pos_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [nhpl_pkg::LEN_W-1:0]           path_length,
  output logic                                 fell_back,
  output logic                                 hop_overflow
);
  import nhpl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_HOP, S_RD_POS, S_DIST, S_DONE
  } st_t;
  localparam int unsigned HOP_CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  pos_t pos_mem [2**IDX_W];
  logic [7:0] hop_mem [2**(2*IDX_W)];

  st_t state;
  logic [IDX_W-1:0] cur, dst;
  logic [HOP_CNT_W-1:0] hops;
  logic [LEN_W-1:0] sum;
  logic missing;
  logic [IDX_W-1:0] nxt;
  logic [7:0] hop_rd;
  pos_t pos_rd, pos_cur;
  logic [IDX_W-1:0] pos_addr;
  logic [2*IDX_W-1:0] hop_addr;
  dist_req_t dreq;
  dist_rsp_t drsp;
  logic accept;
  logic hop_bad;
  logic [LEN_W:0] sum_add;
  logic dist_go;
  logic query_quick;
  logic out_valid_next;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign hop_bad = hop_rd[7] || (32'(hop_rd) >= MAX_POINTS);
  assign query_quick = (32'(point_a) >= MAX_POINTS) || (32'(point_b) >= MAX_POINTS)
                       || (point_a == point_b);

  always_ff @(posedge clk) begin
    if (accept && operation == OP_WRITE_POS && 32'(point_a) < MAX_POINTS)
      pos_mem[point_a] <= '{x: pos_x, y: pos_y, z: pos_z};
    if (accept && operation == OP_WRITE_HOP && 32'(point_a) < MAX_POINTS
        && 32'(point_b) < MAX_POINTS)
      hop_mem[{point_a, point_b}] <= hop_value;
    pos_rd <= pos_mem[pos_addr];
    hop_rd <= hop_mem[hop_addr];
  end

  always_comb begin
    hop_addr = {cur, dst};
    pos_addr = (state == S_RD_HOP) ? cur : nxt;
    if (state == S_RD_POS && hop_bad) pos_addr = dst;
    else if (state == S_RD_POS) pos_addr = hop_rd[IDX_W-1:0];
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (state == S_IDLE && accept && operation == OP_QUERY && query_quick)
      out_valid_next = 1'b1;
    if (state == S_DONE && !out_valid) out_valid_next = 1'b1;
  end

  assign sum_add = {1'b0, sum} + (LEN_W + 1)'(drsp.len);

  nhpl_dist u_dist (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // RD_HOP: table row issued, current position issued.
  // RD_POS: table data back; issue next (or destination) position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (accept && operation == OP_QUERY) begin
            cur <= point_a;
            dst <= point_b;
            hops <= '0;
            sum <= '0;
            if (32'(point_a) >= MAX_POINTS || 32'(point_b) >= MAX_POINTS) begin
              path_length <= '0; fell_back <= 1'b1; hop_overflow <= 1'b0;
            end else if (point_a == point_b) begin
              path_length <= '0; fell_back <= 1'b0; hop_overflow <= 1'b0;
            end else begin
              state <= S_RD_HOP;
            end
          end
        end
        S_RD_HOP: state <= S_RD_POS;
        S_RD_POS: begin
          pos_cur <= pos_rd;
          missing <= hop_bad;
          nxt <= hop_rd[IDX_W-1:0];
          state <= S_DIST;
        end
        S_DIST: begin
          if (drsp.done) begin
            if (missing) begin
              path_length <= drsp.len > (ROOT_W + 1)'(LEN_MAX)
                ? LEN_MAX : LEN_W'(drsp.len);
              fell_back <= 1'b1; hop_overflow <= 1'b0;
              state <= S_DONE;
            end else begin
              sum <= sum_add[LEN_W] ? LEN_MAX : sum_add[LEN_W-1:0];
              cur <= nxt;
              hops <= hops + 1'b1;
              if (nxt == dst) begin
                path_length <= sum_add[LEN_W] ? LEN_MAX : sum_add[LEN_W-1:0];
                fell_back <= 1'b0; hop_overflow <= 1'b0;
                state <= S_DONE;
              end else if (32'(hops) + 1 >= MAX_POINTS) begin
                path_length <= sum_add[LEN_W] ? LEN_MAX : sum_add[LEN_W-1:0];
                fell_back <= 1'b0; hop_overflow <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_RD_HOP;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the second position lands in the cycle after RD_POS: start the distance then
  always_ff @(posedge clk) begin
    if (rst) dist_go <= 1'b0;
    else dist_go <= (state == S_RD_POS);
  end

  always_comb begin
    dreq.start = dist_go;
    dreq.p = pos_cur;
    dreq.q = pos_rd;
  end
endmodule

[sv/nhpl_checker.sv]
`timescale 1ns / 1ps
`include "next_hop_path_length_unit_macros.svh"
module nhpl_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [39:0] path_length,
  input logic fell_back,
  input logic hop_overflow
);
  `NHPL_ASSERT_IMP(a_flags_excl, clk, rst, out_valid, !(fell_back && hop_overflow), "both flags set")
  `NHPL_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(path_length), "stalled result changed")
  `NHPL_ASSERT_IMP(a_stall_full, clk, rst, out_valid && out_stall, in_stall, "input taken while result blocked")
endmodule

bind next_hop_path_length_unit nhpl_checker u_nhpl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .path_length(path_length),
  .fell_back(fell_back), .hop_overflow(hop_overflow)
);
